### src/mean_and_standard_error_top_macros.svh
// assertion macros shared by the mean and standard error block
`ifndef MEAN_AND_STANDARD_ERROR_TOP_MACROS_SVH
`define MEAN_AND_STANDARD_ERROR_TOP_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define MSEM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("msem assertion failed");

// next-cycle implication, clocked on clk, off during reset
`define MSEM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("msem assertion failed");

`endif

### src/msem_pkg.sv
// package: widths, status codes and the set summary type
`timescale 1ns / 1ps
package msem_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int SAMPLE_W    = 16;
    localparam int CNT_W       = 11;
    localparam int SUM_W       = 27;
    localparam int SQS_W       = 41;
    localparam int MAG_W       = 26;
    localparam int DEN_W       = 30;
    localparam int PROD_W      = 52;
    localparam int ERR_W       = 16;
    localparam int STATUS_W    = 2;
    localparam int Q_DEPTH     = 2;
    localparam int Q_AW        = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK   = 2'd0,
        STATUS_FEW  = 2'd1,
        STATUS_MANY = 2'd2
    } status_t;

    typedef struct packed {
        logic [CNT_W-1:0]        n;
        logic signed [SUM_W-1:0] sum;
        logic [SQS_W-1:0]        sq;
        status_t                 status;
    } summary_t;

endpackage

### src/msem_sample_if.sv
// sample channel: valid, ready and one sample with its last flag
`timescale 1ns / 1ps
interface msem_sample_if import msem_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

### src/msem_result_if.sv
// result channel: valid, ready and one result of a set
`timescale 1ns / 1ps
interface msem_result_if import msem_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] mean_value;
    logic [ERR_W-1:0]           std_error;
    logic [STATUS_W-1:0]        status;
    logic [CNT_W-1:0]           sample_count;

    modport source (output valid, output mean_value, output std_error, output status,
                    output sample_count, input ready);
    modport sink   (input valid, input mean_value, input std_error, input status,
                    input sample_count, output ready);
endinterface

### src/msem_front.sv
// front part: accumulates count, sum and sum of squares, classifies each set
`timescale 1ns / 1ps
module msem_front import msem_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    msem_sample_if.sink  samples,
    output logic         push,
    output summary_t     push_data,
    input  logic         full
);

    logic [CNT_W-1:0]        count_reg, count_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [SQS_W-1:0]        sq_reg, sq_next;
    logic                    ovf_reg, ovf_next;

    logic                         accept;
    logic                         take;
    logic signed [2*SAMPLE_W-1:0] square;
    logic [CNT_W-1:0]             cnt_new;
    logic signed [SUM_W-1:0]      sum_new;
    logic [SQS_W-1:0]             sq_new;
    logic                         ovf_new;

    assign samples.ready = !full;
    assign accept        = samples.valid && samples.ready;

    always_comb
    begin
        take    = count_reg < CNT_W'(MAX_SAMPLES);
        square  = samples.sample * samples.sample;
        cnt_new = take ? count_reg + CNT_W'(1) : count_reg;
        sum_new = take ? sum_reg + SUM_W'(samples.sample) : sum_reg;
        sq_new  = take ? sq_reg + SQS_W'($unsigned(square)) : sq_reg;
        ovf_new = ovf_reg || !take;

        push_data.n   = cnt_new;
        push_data.sum = sum_new;
        push_data.sq  = sq_new;
        if (ovf_new)
            push_data.status = STATUS_MANY;
        else if (cnt_new < CNT_W'(2))
            push_data.status = STATUS_FEW;
        else
            push_data.status = STATUS_OK;

        push = accept && samples.last;

        count_next = count_reg;
        sum_next   = sum_reg;
        sq_next    = sq_reg;
        ovf_next   = ovf_reg;
        if (accept)
        begin
            if (samples.last)
            begin
                count_next = '0;
                sum_next   = '0;
                sq_next    = '0;
                ovf_next   = 1'b0;
            end
            else
            begin
                count_next = cnt_new;
                sum_next   = sum_new;
                sq_next    = sq_new;
                ovf_next   = ovf_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            sq_reg    <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
            sq_reg    <= sq_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

### src/msem_queue.sv
// short queue of set summaries between front and back
`timescale 1ns / 1ps
`include "mean_and_standard_error_top_macros.svh"
module msem_queue import msem_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  summary_t push_data,
    output logic     full,
    input  logic     pop,
    output summary_t pop_data,
    output logic     empty
);

    summary_t            slot_reg [Q_DEPTH];
    logic [Q_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]  cnt_reg, cnt_next;

    assign full     = cnt_reg == Q_CNT_W'(Q_DEPTH);
    assign empty    = cnt_reg == '0;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + Q_AW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + Q_AW'(1);
        if (push && !pop)
            cnt_next = cnt_reg + Q_CNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - Q_CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // front must hold off while the queue is full, back must not pop it empty
    `MSEM_ASSERT_IMP(a_no_push_full, push, !full || pop)
    `MSEM_ASSERT_IMP(a_no_pop_empty, pop, !empty)
    `MSEM_ASSERT_NXT(a_push_fills, push && !pop, cnt_reg != '0)

endmodule

### src/msem_back.sv
// back part: mean division, variance products, division and square root
`timescale 1ns / 1ps
`include "mean_and_standard_error_top_macros.svh"
module msem_back import msem_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          empty,
    input  summary_t      pop_data,
    output logic          pop,
    msem_result_if.source results
);

    localparam int NN_W        = 2 * CNT_W;
    localparam int DENF_W      = NN_W + CNT_W;
    localparam int STEP_W      = $clog2(PROD_W + 1);
    localparam int SQRT_STEPS  = PROD_W / 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_SUB,
        ST_DIVM,
        ST_DIVS,
        ST_SQRT,
        ST_OUT
    } state_t;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        n_reg, n_next;
    logic                    neg_reg, neg_next;
    logic [MAG_W-1:0]        mag_reg, mag_next;
    logic [SQS_W-1:0]        sq_reg, sq_next;
    status_t                 status_reg, status_next;
    logic [PROD_W-1:0]       nsq_reg, nsq_next;
    logic [PROD_W-1:0]       s1sq_reg, s1sq_next;
    logic [NN_W-1:0]         nn_reg, nn_next;
    logic [DEN_W-1:0]        den_reg, den_next;
    logic [PROD_W-1:0]       num_reg, num_next;
    logic [PROD_W-1:0]       dvd_reg, dvd_next;
    logic [DEN_W-1:0]        dvs_reg, dvs_next;
    logic [DEN_W-1:0]        rem_reg, rem_next;
    logic [PROD_W-1:0]       root_reg, root_next;
    logic [PROD_W-1:0]       bit_reg, bit_next;
    logic [STEP_W-1:0]       cnt_reg, cnt_next;
    logic signed [SAMPLE_W-1:0] mean_reg, mean_next;
    logic [ERR_W-1:0]        err_reg, err_next;

    logic                    out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] out_mean_reg, out_mean_next;
    logic [ERR_W-1:0]        out_err_reg, out_err_next;
    logic [STATUS_W-1:0]     out_status_reg, out_status_next;
    logic [CNT_W-1:0]        out_count_reg, out_count_next;

    // one restoring divide step
    logic [DEN_W:0]          trial;
    logic                    div_ge;
    logic [DEN_W-1:0]        div_rem;
    logic [PROD_W-1:0]       div_dvd;
    // one square root step
    logic [PROD_W:0]         sq_sum;
    logic                    sq_ge;
    logic [PROD_W-1:0]       sq_v;
    logic [PROD_W-1:0]       sq_root;
    logic [MAG_W-1:0]        quo_mean;
    logic [DENF_W-1:0]       den_full;

    assign results.valid        = out_valid_reg;
    assign results.mean_value   = out_mean_reg;
    assign results.std_error    = out_err_reg;
    assign results.status       = out_status_reg;
    assign results.sample_count = out_count_reg;

    always_comb
    begin
        trial   = {rem_reg, dvd_reg[PROD_W-1]};
        div_ge  = trial >= {1'b0, dvs_reg};
        div_rem = div_ge ? DEN_W'(trial - {1'b0, dvs_reg}) : trial[DEN_W-1:0];
        div_dvd = {dvd_reg[PROD_W-2:0], div_ge};

        sq_sum  = {1'b0, root_reg} + {1'b0, bit_reg};
        sq_ge   = {1'b0, dvd_reg} >= sq_sum;
        sq_v    = sq_ge ? PROD_W'({1'b0, dvd_reg} - sq_sum) : dvd_reg;
        sq_root = sq_ge ? (root_reg >> 1) + bit_reg : root_reg >> 1;

        quo_mean = div_dvd[MAG_W-1:0];
        den_full = DENF_W'(nn_reg) * DENF_W'(n_reg - CNT_W'(1));
    end

    always_comb
    begin
        state_next      = state_reg;
        n_next          = n_reg;
        neg_next        = neg_reg;
        mag_next        = mag_reg;
        sq_next         = sq_reg;
        status_next     = status_reg;
        nsq_next        = nsq_reg;
        s1sq_next       = s1sq_reg;
        nn_next         = nn_reg;
        den_next        = den_reg;
        num_next        = num_reg;
        dvd_next        = dvd_reg;
        dvs_next        = dvs_reg;
        rem_next        = rem_reg;
        root_next       = root_reg;
        bit_next        = bit_reg;
        cnt_next        = cnt_reg;
        mean_next       = mean_reg;
        err_next        = err_reg;
        out_valid_next  = out_valid_reg && !results.ready;
        out_mean_next   = out_mean_reg;
        out_err_next    = out_err_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        pop             = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    pop         = 1'b1;
                    n_next      = pop_data.n;
                    neg_next    = pop_data.sum < 0;
                    mag_next    = MAG_W'(pop_data.sum < 0 ? -pop_data.sum : pop_data.sum);
                    sq_next     = pop_data.sq;
                    status_next = pop_data.status;
                    state_next  = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                nsq_next   = PROD_W'(n_reg) * PROD_W'(sq_reg);
                nn_next    = NN_W'(n_reg) * NN_W'(n_reg);
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                s1sq_next  = PROD_W'(mag_reg) * PROD_W'(mag_reg);
                den_next   = den_full[DEN_W-1:0];
                state_next = ST_SUB;
            end
            ST_SUB:
            begin
                num_next = nsq_reg - s1sq_reg;
                err_next = '0;
                if (n_reg == '0)
                begin
                    // empty set: mean is zero, nothing to divide
                    mean_next  = '0;
                    state_next = ST_OUT;
                end
                else
                begin
                    dvd_next   = {mag_reg, {(PROD_W - MAG_W){1'b0}}};
                    dvs_next   = DEN_W'(n_reg);
                    rem_next   = '0;
                    cnt_next   = STEP_W'(MAG_W);
                    state_next = ST_DIVM;
                end
            end
            ST_DIVM:
            begin
                dvd_next = div_dvd;
                rem_next = div_rem;
                cnt_next = cnt_reg - STEP_W'(1);
                if (cnt_reg == STEP_W'(1))
                begin
                    mean_next = neg_reg ? SAMPLE_W'(~quo_mean[SAMPLE_W-1:0] + SAMPLE_W'(1))
                                        : SAMPLE_W'(quo_mean[SAMPLE_W-1:0]);
                    // an overrun set still reports the spread of its kept samples
                    if (n_reg >= CNT_W'(2))
                    begin
                        dvd_next   = num_reg;
                        dvs_next   = den_reg;
                        rem_next   = '0;
                        cnt_next   = STEP_W'(PROD_W);
                        state_next = ST_DIVS;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_DIVS:
            begin
                dvd_next = div_dvd;
                rem_next = div_rem;
                cnt_next = cnt_reg - STEP_W'(1);
                if (cnt_reg == STEP_W'(1))
                begin
                    root_next  = '0;
                    bit_next   = PROD_W'(1) << (PROD_W - 2);
                    cnt_next   = STEP_W'(SQRT_STEPS);
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                dvd_next  = sq_v;
                root_next = sq_root;
                bit_next  = bit_reg >> 2;
                cnt_next  = cnt_reg - STEP_W'(1);
                if (cnt_reg == STEP_W'(1))
                begin
                    err_next   = sq_root[ERR_W-1:0];
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_mean_next   = mean_reg;
                    out_err_next    = err_reg;
                    out_status_next = status_reg;
                    out_count_next  = n_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            n_reg          <= '0;
            neg_reg        <= 1'b0;
            mag_reg        <= '0;
            sq_reg         <= '0;
            status_reg     <= STATUS_OK;
            nsq_reg        <= '0;
            s1sq_reg       <= '0;
            nn_reg         <= '0;
            den_reg        <= '0;
            num_reg        <= '0;
            dvd_reg        <= '0;
            dvs_reg        <= '0;
            rem_reg        <= '0;
            root_reg       <= '0;
            bit_reg        <= '0;
            cnt_reg        <= '0;
            mean_reg       <= '0;
            err_reg        <= '0;
            out_mean_reg   <= '0;
            out_err_reg    <= '0;
            out_status_reg <= '0;
            out_count_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            n_reg          <= n_next;
            neg_reg        <= neg_next;
            mag_reg        <= mag_next;
            sq_reg         <= sq_next;
            status_reg     <= status_next;
            nsq_reg        <= nsq_next;
            s1sq_reg       <= s1sq_next;
            nn_reg         <= nn_next;
            den_reg        <= den_next;
            num_reg        <= num_next;
            dvd_reg        <= dvd_next;
            dvs_reg        <= dvs_next;
            rem_reg        <= rem_next;
            root_reg       <= root_next;
            bit_reg        <= bit_next;
            cnt_reg        <= cnt_next;
            mean_reg       <= mean_next;
            err_reg        <= err_next;
            out_mean_reg   <= out_mean_next;
            out_err_reg    <= out_err_next;
            out_status_reg <= out_status_next;
            out_count_reg  <= out_count_next;
        end
    end

    // a set with fewer than two samples never reports a nonzero error
    `MSEM_ASSERT_IMP(a_few_err_zero, out_valid_reg && (out_status_reg == STATUS_FEW), out_err_reg == '0)
    // square root only runs for sets with at least two samples
    `MSEM_ASSERT_IMP(a_sqrt_two_min, state_reg == ST_SQRT, n_reg >= CNT_W'(2))
    // a new result only comes out of the output state
    `MSEM_ASSERT_IMP(a_load_from_out, $rose(out_valid_reg), $past(state_reg) == ST_OUT)

endmodule

### src/mean_and_standard_error_top.sv
// top level: mean and standard error of the mean over sets of Q8.8 samples
//
//   channel   dir  payload                                         transfer when
//   samples   in   sample[15:0] signed, last                       valid && ready
//   results   out  mean_value, std_error, status, sample_count     valid && ready
//
// samples transfer one per cycle while the summary queue has room; the
// accumulators add one sample per cycle, so the input side sustains full rate
// the back part runs each set through multiplies, a subtract, a bit-serial mean
// divide, a bit-serial variance divide and a two-bits-a-step square root, with
// only the mean divide below two samples and none for an empty set; two set
// summaries queue up in between; rst_n clears the accumulators, the queue and
// the result register at once; a stalled result holds in the output register
// while the back part starts the next set; sets quicker than it stall the input
`timescale 1ns / 1ps
module mean_and_standard_error_top import msem_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    msem_sample_if.sink   samples,
    msem_result_if.source results
);

    // summary of one finished set, from front to back
    logic     push;
    summary_t push_data;
    logic     full;
    logic     pop;
    summary_t pop_data;
    logic     empty;

    // front: accumulate and classify each set
    msem_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    // queue: lets the accumulators run ahead of the arithmetic
    msem_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    // back: mean, variance, square root, output register
    msem_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (empty),
        .pop_data (pop_data),
        .pop      (pop),
        .results  (results)
    );

endmodule

### test/msem_checker.sv
// checker: watches both channels, predicts each set result and compares it
`timescale 1ns / 1ps
module msem_checker import msem_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    msem_sample_if samples,
    msem_result_if results,
    output int     errors,
    output int     outstanding
);

    typedef struct {
        logic signed [SAMPLE_W-1:0] mean_value;
        logic [ERR_W-1:0]           std_error;
        status_t                    status;
        logic [CNT_W-1:0]           sample_count;
    } set_result_t;

    // running statistics of the set being received
    logic [CNT_W-1:0]        set_count      = '0;
    logic signed [SUM_W-1:0] set_sum        = '0;
    logic [SQS_W-1:0]        set_sq_sum     = '0;
    logic                    set_overflowed = 1'b0;

    set_result_t pending_results[$];

    function automatic longint unsigned floor_sqrt(input longint unsigned value);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= value)
                root = trial;
        end
        return root;
    endfunction

    // exact one-pass variance of the mean, raw q8.8 units cancel out
    function automatic set_result_t summarize_set();
        longint unsigned n;
        longint unsigned mag;
        longint unsigned spread;
        longint unsigned den;
        longint          total;
        set_result_t     r;
        n     = set_count;
        total = set_sum;
        r.mean_value   = (n == 0) ? '0 : SAMPLE_W'(total / longint'(n));
        r.std_error    = '0;
        r.sample_count = set_count;
        if (n >= 2)
        begin
            mag    = (total < 0) ? -total : total;
            spread = n * longint'(set_sq_sum) - mag * mag;
            den    = n * n * (n - 1);
            r.std_error = ERR_W'(floor_sqrt(spread / den));
        end
        if (set_overflowed)
            r.status = STATUS_MANY;
        else if (n < 2)
            r.status = STATUS_FEW;
        else
            r.status = STATUS_OK;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        set_result_t want;
        longint      x;
        if (!rst_n)
        begin
            set_count      = '0;
            set_sum        = '0;
            set_sq_sum     = '0;
            set_overflowed = 1'b0;
            pending_results.delete();
            errors         = 0;
            outstanding    = 0;
        end
        else
        begin
            // a result can only belong to an older set, so check it first
            if (results.valid && results.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result transfer with no set pending");
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (results.mean_value !== want.mean_value)
                    begin
                        $error("mean_value: expected %0d, got %0d",
                               want.mean_value, results.mean_value);
                        errors++;
                    end
                    if (results.std_error !== want.std_error)
                    begin
                        $error("std_error: expected %0d, got %0d",
                               want.std_error, results.std_error);
                        errors++;
                    end
                    if (results.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, results.status);
                        errors++;
                    end
                    if (results.sample_count !== want.sample_count)
                    begin
                        $error("sample_count: expected %0d, got %0d",
                               want.sample_count, results.sample_count);
                        errors++;
                    end
                end
            end
            if (samples.valid && samples.ready)
            begin
                x = samples.sample;
                // a full set drops the sample, even a last one
                if (set_count < MAX_SAMPLES)
                begin
                    set_count  = set_count + 1'b1;
                    set_sum    = set_sum + SUM_W'(x);
                    set_sq_sum = set_sq_sum + SQS_W'(x * x);
                end
                else
                    set_overflowed = 1'b1;
                if (samples.last)
                begin
                    pending_results.push_back(summarize_set());
                    set_count      = '0;
                    set_sum        = '0;
                    set_sq_sum     = '0;
                    set_overflowed = 1'b0;
                end
            end
            outstanding = pending_results.size();
        end
    end

endmodule

### test/tb_mean_and_standard_error_top.sv
// testbench top: sample stimulus, result back-pressure, watchdog and verdict
`timescale 1ns / 1ps
module tb_mean_and_standard_error_top;
    import msem_pkg::*;

    // under two thousand samples and a few hundred sets, even at the slowest
    // back part per set, stay far below this
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 400;
    // long receiver hold-off, enough to fill the summary queue several times
    localparam int HOLD_CYCLES  = 400;
    // settle time after the last expected result, well above one set's latency
    localparam int DRAIN_CYCLES = 200;

    // how the samples of one random set are drawn
    typedef enum int {
        SHAPE_WIDE,     // any 16-bit value
        SHAPE_RAIL,     // only the two extremes
        SHAPE_CLUSTER,  // close to a random center
        SHAPE_FLAT      // one value repeated, zero spread
    } shape_t;

    logic clk;
    logic rst_n;
    int   errors;
    int   outstanding;
    int   cycle_count;
    int   stall_left;
    bit   calm;         // no idling on either side near the end
    bit   hold_req;     // asks the receiver for one long hold-off

    msem_sample_if samples_if ();
    msem_result_if results_if ();

    mean_and_standard_error_top u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_if),
        .results (results_if)
    );

    msem_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .samples     (samples_if),
        .results     (results_if),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // reset once, at the start of the run
    initial
    begin
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    // watchdog on the whole run
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // result side: short random stalls, plus one long hold-off on request
    initial
    begin
        results_if.ready <= 1'b0;
        stall_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                results_if.ready <= 1'b0;
                stall_left--;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                // ready goes low now and stays low while a random stall_left runs down
                results_if.ready <= 1'b0;
                stall_left = $urandom_range(0, 3);
            end
            else
                results_if.ready <= 1'b1;
        end
    end

    // one sample transfer, maybe after a short idle burst; valid stays high
    // from one transfer to the next unless a gap is taken
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value, input logic is_last);
        int gap;
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 4);
            samples_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        samples_if.valid  <= 1'b1;
        samples_if.sample <= value;
        samples_if.last   <= is_last;
        do
            @(posedge clk);
        while (!samples_if.ready);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] draw_sample(input shape_t shape,
                                                               input int center);
        case (shape)
            SHAPE_WIDE:    return SAMPLE_W'($urandom);
            SHAPE_RAIL:    return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            SHAPE_CLUSTER: return SAMPLE_W'(center + int'($urandom_range(0, 512)) - 256);
            default:       return SAMPLE_W'(center);
        endcase
    endfunction

    // a whole set, last flag on its final sample
    task automatic send_set(input int len, input shape_t shape);
        int center;
        center = int'($urandom_range(0, 65535)) - 32768;
        for (int i = 0; i < len; i++)
            send_sample(draw_sample(shape, center), i == len - 1);
    endtask

    // stimulus and verdict
    initial
    begin
        int     sent;
        int     pick;
        int     len;
        shape_t shape;

        samples_if.valid  <= 1'b0;
        samples_if.sample <= '0;
        samples_if.last   <= 1'b0;
        calm     = 1'b0;
        hold_req = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);

        // single-sample sets: fewer than two samples, mean is the sample
        send_sample(16'sh7fff, 1'b1);
        send_sample(16'sh8000, 1'b1);
        send_sample(16'sh0000, 1'b1);
        // two extremes: largest spread for a pair
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7fff, 1'b1);
        // equal pair, zero spread
        send_sample(16'sh7fff, 1'b0);
        send_sample(16'sh7fff, 1'b1);
        // negative odd sum: mean truncates toward zero, not down
        send_sample(-16'sd3, 1'b0);
        send_sample(-16'sd2, 1'b1);
        send_sample(-16'sd256, 1'b0);
        send_sample(16'sd256, 1'b0);
        send_sample(16'sd512, 1'b1);

        // overrun set: kept samples are the most negative but one, so sum and
        // square sum run near their extremes with a nonzero spread; the extra
        // samples and the last one are dropped
        for (int i = 0; i < MAX_SAMPLES + 3; i++)
            send_sample((i < MAX_SAMPLES - 1) ? 16'sh8000 : 16'sh7fff,
                        i == MAX_SAMPLES + 2);
        // the set after an overrun starts clean
        send_sample(16'sd100, 1'b1);

        // back-pressure: receiver holds off while short sets keep coming,
        // so the summary queue fills and the sample input stalls
        hold_req = 1'b1;
        for (int i = 0; i < 20; i++)
            send_set($urandom_range(2, 3), SHAPE_WIDE);

        // random sets, mostly short, a few long ones; calm at the end
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 14)
                len = $urandom_range(1, 6);
            else if (pick < 19)
                len = $urandom_range(7, 40);
            else
                len = $urandom_range(41, 150);
            shape = shape_t'($urandom_range(0, 3));
            calm  = (sent > RANDOM_ITEMS * 4 / 5);
            send_set(len, shape);
            sent += len;
        end
        samples_if.valid <= 1'b0;

        // wait for every expected result, then let the back part settle
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (outstanding != 0)
            $error("%0d expected results never arrived", outstanding);
        if (errors == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### files.f
+incdir+src
src/msem_pkg.sv
src/msem_sample_if.sv
src/msem_result_if.sv
src/msem_front.sv
src/msem_queue.sv
src/msem_back.sv
src/mean_and_standard_error_top.sv
test/msem_checker.sv
test/tb_mean_and_standard_error_top.sv
